>>> design/bhcs_pkg.sv
package bhcs_pkg;

    localparam int DUTY_W   = 11;
    localparam int REQ_W    = 16;
    localparam int POS_W    = 3;
    localparam int PERIOD_W = 32;
    localparam int RPM_W    = 26;
    localparam int SPR_W    = 8;
    localparam int PHASES   = 3;
    localparam int SWITCHES = 2 * PHASES;

    localparam int DUTY_MAX       = 2000;
    localparam int DUTY_FIELD_MAX = (1 << DUTY_W) - 1;
    localparam int DUTY_LIMIT     = (DUTY_MAX < DUTY_FIELD_MAX) ? DUTY_MAX : DUTY_FIELD_MAX;

    localparam int TICK_HZ_DEFAULT = 1000000;
    localparam int SECONDS_PER_MIN = 60;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [RPM_W-1:0] RPM_MAX = '1;
    localparam logic [SPR_W-1:0] SPR_RESET = 8'd1;

    localparam logic [POS_W-1:0] POS_INVALID = 3'd0;
    localparam logic [POS_W-1:0] POS_INDEX   = 3'd1;
    localparam logic [POS_W-1:0] POS_ILLEGAL = 3'd7;

    // Phase numbers 0..2 are A..C; NO_PHASE marks an invalid position.
    localparam logic [1:0] NO_PHASE = 2'd3;
    localparam logic [1:0] FWD_HIGH [8] = '{2'd3, 2'd1, 2'd2, 2'd2, 2'd0, 2'd1, 2'd0, 2'd3};
    localparam logic [1:0] FWD_LOW  [8] = '{2'd3, 2'd0, 2'd1, 2'd0, 2'd2, 2'd2, 2'd1, 2'd3};

    typedef enum logic [1:0] {
        DIR_OFF = 2'd0,
        DIR_FWD = 2'd1,
        DIR_REV = 2'd2
    } drive_dir_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_DIV,
        BK_OUT
    } back_state_t;

    typedef logic [DUTY_W-1:0] duty_t;

    // Switch order: A, B, C upper, then A, B, C lower.
    typedef duty_t [SWITCHES-1:0] duty_vec_t;

    typedef struct packed {
        logic                    hall_a;
        logic                    hall_b;
        logic                    hall_c;
        logic signed [REQ_W-1:0] speed_request;
    } hall_in_t;

    typedef struct packed {
        duty_t                a_high_duty;
        duty_t                b_high_duty;
        duty_t                c_high_duty;
        duty_t                a_low_duty;
        duty_t                b_low_duty;
        duty_t                c_low_duty;
        logic [POS_W-1:0]     hall_position;
        logic [1:0]           drive_direction;
        logic                 speed_updated;
        logic [PERIOD_W-1:0]  period_ticks;
        logic [RPM_W-1:0]     speed_rpm;
    } hall_out_t;

    typedef struct packed {
        duty_vec_t            duty;
        logic [POS_W-1:0]     pos;
        drive_dir_t           dir;
        logic                 measure;
        logic [PERIOD_W-1:0]  period;
    } q_entry_t;

endpackage

>>> design/bldc_hall_commutation_speed_top.sv
// Six-step commutation with hall-based speed measurement.
// Each transfer on the sample side is one timer tick: three hall levels and a
// signed drive request. Each tick yields exactly one result on the result side:
// six switch duties, the decoded position, the direction, and the held period
// and speed, with speed_updated set on ticks that closed a measured period.
// Sample side: push/full, taken when push is high and full is low. Result side:
// empty/pop, the oldest result shows while empty is low and leaves on pop.
// wr_en/wr_data write the sensors-per-revolution register (reset value 1).
// The front decodes each tick in its accepting cycle and places it in a two-entry
// queue. A plain tick passes through the queue and the output register; plain
// ticks flow at one per cycle while the back end is idle and the receiver pops.
// A tick that ends a period passes the back end in order: taken from the queue,
// the period times sensor count product, one restoring division step per
// quotient bit (26 bits at the default tick rate), and the write of the
// result; the divider is the rate-setting unit. Reset clears the timing state,
// the held speed and the queue. While the receiver stalls, one result waits in
// the output register, the queue fills, and full then holds off further ticks.
module bldc_hall_commutation_speed_top #(
    parameter int TICK_HZ = bhcs_pkg::TICK_HZ_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  bhcs_pkg::hall_in_t         sample,
    output logic                       empty,
    input  logic                       pop,
    output bhcs_pkg::hall_out_t        result,
    input  logic                       wr_en,
    input  logic [bhcs_pkg::SPR_W-1:0] wr_data
);
    import bhcs_pkg::*;

    logic [SPR_W-1:0] spr_reg, spr_next;
    logic             q_push, q_full, q_pop, q_empty;
    q_entry_t         q_wr_data, q_rd_data;

    assign spr_next = wr_en ? wr_data : spr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spr_reg <= SPR_RESET;
        end
        else
        begin
            spr_reg <= spr_next;
        end
    end

    bhcs_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .sample (sample),
        .full   (full),
        .q_push (q_push),
        .q_data (q_wr_data),
        .q_full (q_full)
    );

    bhcs_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr_data),
        .full    (q_full),
        .pop     (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    bhcs_back #(
        .TICK_HZ (TICK_HZ)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .spr     (spr_reg),
        .q_empty (q_empty),
        .q_data  (q_rd_data),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

    // The back end never takes an entry from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
        else $error("queue read while empty");

    // With the drive off, all six switches carry zero duty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.drive_direction == DIR_OFF) |->
        (result.a_high_duty == '0 && result.b_high_duty == '0 &&
         result.c_high_duty == '0 && result.a_low_duty == '0 &&
         result.b_low_duty == '0 && result.c_low_duty == '0))
        else $error("duty driven while off");

    // A fresh measurement always carries a nonzero period.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.speed_updated) |-> (result.period_ticks != '0))
        else $error("speed update with zero period");

endmodule

>>> design/bhcs_fifo.sv
module bhcs_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  bhcs_pkg::q_entry_t wr_data,
    output logic               full,
    input  logic               pop,
    output bhcs_pkg::q_entry_t rd_data,
    output logic               empty
);
    import bhcs_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    q_entry_t         slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> design/bhcs_front.sv
module bhcs_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  bhcs_pkg::hall_in_t sample,
    output logic               full,
    output logic               q_push,
    output bhcs_pkg::q_entry_t q_data,
    input  logic               q_full
);
    import bhcs_pkg::*;

    logic [POS_W-1:0]    prev_pos_reg, prev_pos_next;
    logic [PERIOD_W-1:0] tick_reg, tick_next;
    logic                started_reg, started_next;

    logic                accept;
    logic [POS_W-1:0]    pos_raw, pos;
    logic [PERIOD_W-1:0] tick_inc;
    logic                entry;
    logic [REQ_W:0]      mag;
    duty_t               duty;
    drive_dir_t          dir;
    logic [1:0]          hi, lo;
    logic [2:0]          hi_idx, lo_idx;
    duty_vec_t           duty_vec;

    assign accept = push && !q_full;
    assign full   = q_full;
    assign q_push = accept;

    always_comb
    begin
        pos_raw = {sample.hall_c, sample.hall_b, sample.hall_a};
        pos     = (pos_raw == POS_ILLEGAL) ? POS_INVALID : pos_raw;

        // The counter saturates so a stalled motor never wraps the period.
        tick_inc = (tick_reg == '1) ? tick_reg : tick_reg + 1'b1;
        entry    = (prev_pos_reg != POS_INDEX) && (pos == POS_INDEX);

        if (sample.speed_request == '0)
        begin
            dir = DIR_OFF;
            mag = '0;
        end
        else if (sample.speed_request[REQ_W-1])
        begin
            dir = DIR_REV;
            mag = -{sample.speed_request[REQ_W-1], sample.speed_request};
        end
        else
        begin
            dir = DIR_FWD;
            mag = {1'b0, sample.speed_request};
        end
        duty = (mag > (REQ_W + 1)'(DUTY_LIMIT)) ? DUTY_W'(DUTY_LIMIT) : mag[DUTY_W-1:0];

        if (dir == DIR_REV)
        begin
            hi = FWD_LOW[pos];
            lo = FWD_HIGH[pos];
        end
        else
        begin
            hi = FWD_HIGH[pos];
            lo = FWD_LOW[pos];
        end
        hi_idx   = 3'(hi);
        lo_idx   = 3'(lo) + 3'(PHASES);
        duty_vec = '0;
        if (dir != DIR_OFF && hi != NO_PHASE && lo != NO_PHASE)
        begin
            duty_vec[hi_idx] = duty;
            duty_vec[lo_idx] = duty;
        end

        q_data.duty    = duty_vec;
        q_data.pos     = pos;
        q_data.dir     = dir;
        q_data.measure = entry && started_reg;
        q_data.period  = tick_inc;

        prev_pos_next = prev_pos_reg;
        tick_next     = tick_reg;
        started_next  = started_reg;
        if (accept)
        begin
            prev_pos_next = pos;
            tick_next     = entry ? '0 : tick_inc;
            started_next  = started_reg || entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_pos_reg <= POS_INVALID;
            tick_reg     <= '0;
            started_reg  <= 1'b0;
        end
        else
        begin
            prev_pos_reg <= prev_pos_next;
            tick_reg     <= tick_next;
            started_reg  <= started_next;
        end
    end

endmodule

>>> design/bhcs_back.sv
module bhcs_back #(
    parameter int TICK_HZ = bhcs_pkg::TICK_HZ_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [bhcs_pkg::SPR_W-1:0] spr,
    input  logic                       q_empty,
    input  bhcs_pkg::q_entry_t         q_data,
    output logic                       q_pop,
    input  logic                       pop,
    output logic                       empty,
    output bhcs_pkg::hall_out_t        result
);
    import bhcs_pkg::*;

    localparam logic [63:0] DIVIDEND = 64'(SECONDS_PER_MIN) * 64'(TICK_HZ);
    localparam int DVD_W     = $clog2(DIVIDEND + 64'd1);
    localparam int DIVISOR_W = PERIOD_W + SPR_W;
    localparam int CNT_W     = $clog2(DVD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

    back_state_t          state_reg, state_next;
    logic                 out_valid_reg, out_valid_next;
    logic [PERIOD_W-1:0]  held_period_reg, held_period_next;
    logic [RPM_W-1:0]     held_rpm_reg, held_rpm_next;

    q_entry_t             work_reg, work_next;
    logic [DIVISOR_W-1:0] divisor_reg, divisor_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0]     dvd_reg, dvd_next;
    logic [DVD_W-1:0]     quo_reg, quo_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    hall_out_t            out_reg, out_next;

    logic                 slot_free;
    logic [PERIOD_W-1:0]  per_nz;
    logic [SPR_W-1:0]     spr_nz;
    logic [DIVISOR_W:0]   shifted;
    logic [DIVISOR_W:0]   diff;
    logic                 fits;
    logic [63:0]          quo_wide;
    logic [RPM_W-1:0]     rpm;

    function automatic hall_out_t pack_result(
        input q_entry_t            e,
        input logic                updated,
        input logic [PERIOD_W-1:0] period,
        input logic [RPM_W-1:0]    speed
    );
        hall_out_t r;
        r.a_high_duty     = e.duty[0];
        r.b_high_duty     = e.duty[1];
        r.c_high_duty     = e.duty[2];
        r.a_low_duty      = e.duty[3];
        r.b_low_duty      = e.duty[4];
        r.c_low_duty      = e.duty[5];
        r.hall_position   = e.pos;
        r.drive_direction = e.dir;
        r.speed_updated   = updated;
        r.period_ticks    = period;
        r.speed_rpm       = speed;
        return r;
    endfunction

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    always_comb
    begin
        slot_free = !out_valid_reg || pop;
        per_nz    = (work_reg.period == '0) ? PERIOD_W'(1) : work_reg.period;
        spr_nz    = (spr == '0) ? SPR_W'(1) : spr;

        // One restoring division step: one quotient bit per cycle.
        shifted = {rem_reg, dvd_reg[DVD_W-1]};
        diff    = shifted - {1'b0, divisor_reg};
        fits    = !diff[DIVISOR_W];

        quo_wide = 64'(quo_reg);
        rpm      = (quo_wide > 64'(RPM_MAX)) ? RPM_MAX : quo_wide[RPM_W-1:0];

        state_next       = state_reg;
        out_valid_next   = out_valid_reg;
        held_period_next = held_period_reg;
        held_rpm_next    = held_rpm_reg;
        work_next        = work_reg;
        divisor_next     = divisor_reg;
        rem_next         = rem_reg;
        dvd_next         = dvd_reg;
        quo_next         = quo_reg;
        cnt_next         = cnt_reg;
        out_next         = out_reg;
        q_pop            = 1'b0;

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    if (q_data.measure)
                    begin
                        q_pop      = 1'b1;
                        work_next  = q_data;
                        state_next = BK_MUL;
                    end
                    else if (slot_free)
                    begin
                        q_pop          = 1'b1;
                        out_next       = pack_result(q_data, 1'b0, held_period_reg,
                                                     held_rpm_reg);
                        out_valid_next = 1'b1;
                    end
                end
            end
            BK_MUL:
            begin
                divisor_next = DIVISOR_W'(per_nz) * DIVISOR_W'(spr_nz);
                rem_next     = '0;
                dvd_next     = DIVIDEND[DVD_W-1:0];
                quo_next     = '0;
                cnt_next     = '0;
                state_next   = BK_DIV;
            end
            BK_DIV:
            begin
                rem_next = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
                dvd_next = dvd_reg << 1;
                quo_next = {quo_reg[DVD_W-2:0], fits};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = BK_OUT;
                end
            end
            BK_OUT:
            begin
                if (slot_free)
                begin
                    held_period_next = work_reg.period;
                    held_rpm_next    = rpm;
                    out_next         = pack_result(work_reg, 1'b1, work_reg.period, rpm);
                    out_valid_next   = 1'b1;
                    state_next       = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= BK_IDLE;
            out_valid_reg   <= 1'b0;
            held_period_reg <= '0;
            held_rpm_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            out_valid_reg   <= out_valid_next;
            held_period_reg <= held_period_next;
            held_rpm_reg    <= held_rpm_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg    <= work_next;
        divisor_reg <= divisor_next;
        rem_reg     <= rem_next;
        dvd_reg     <= dvd_next;
        quo_reg     <= quo_next;
        cnt_reg     <= cnt_next;
        out_reg     <= out_next;
    end

endmodule
